@@ rtl/sdtq_pkg.sv @@
// shared types and constants for the sorted deadline timer queue
package sdtq_pkg;

  // field widths fixed by the interface
  localparam int unsigned T_W    = 63;
  localparam int unsigned ID_W   = 8;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned EV_W   = 2;

  // parameter defaults
  localparam int unsigned DEPTH_DEF   = 16;
  localparam int unsigned ID_BITS_DEF = 8;

  // request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_START = 2'd0,
    KIND_STOP  = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_CLOCK = 2'd3
  } kind_e;

  // result events
  typedef enum logic [EV_W-1:0] {
    EV_ACK       = 2'd0,
    EV_EXPIRED   = 2'd1,
    EV_CANCELLED = 2'd2,
    EV_FULL      = 2'd3
  } event_e;

endpackage

@@ rtl/sdtq_ram.sv @@
// generic simple dual port ram with registered read
module sdtq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/sorted_deadline_timer_queue.sv @@
// sorted deadline timer queue: entries in a circular ram, sequencer for insert, stop, tick, clock change
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o  kind, timer_id, duration, is_relative, now
//   out      output     out_valid_o / out_stall_i event_res, timer_id_res, next_deadline,
//                                                 queue_empty, last
//
// work per item: start moves the entries with later deadlines up one place, or gives
// the full result with no pass; stop reads every queued entry; tick reads from the head
// and reports each popped entry; clock change reports every entry as cancelled. all reads
// go through the one ram read port with its registered read. reset empties the queue at once, no clearing pass.
// one item at a time; a stalled result holds the sequencer and with it the input.
module sorted_deadline_timer_queue #(
  parameter int unsigned DEPTH   = sdtq_pkg::DEPTH_DEF,
  parameter int unsigned ID_BITS = sdtq_pkg::ID_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [sdtq_pkg::KIND_W-1:0]   kind_i,
  input  logic [sdtq_pkg::ID_W-1:0]     timer_id_i,
  input  logic [sdtq_pkg::T_W-1:0]      duration_i,
  input  logic                          is_relative_i,
  input  logic [sdtq_pkg::T_W-1:0]      now_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [sdtq_pkg::EV_W-1:0]     event_res_o,
  output logic [sdtq_pkg::ID_W-1:0]     timer_id_res_o,
  output logic [sdtq_pkg::T_W-1:0]      next_deadline_o,
  output logic                          queue_empty_o,
  output logic                          last_o
);
  import sdtq_pkg::*;

  localparam int unsigned AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned IDW = (ID_BITS < ID_W) ? ID_BITS : ID_W;
  localparam int unsigned DW  = T_W + IDW;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW:0]   DEPTH_X = (CW + 1)'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  // sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INS_RD  = 4'd1;
  localparam logic [3:0] S_INS_CMP = 4'd2;
  localparam logic [3:0] S_STP_RD  = 4'd3;
  localparam logic [3:0] S_STP_CMP = 4'd4;
  localparam logic [3:0] S_SCN_RD  = 4'd5;
  localparam logic [3:0] S_SCN_CMP = 4'd6;
  localparam logic [3:0] S_EMT_RD  = 4'd7;
  localparam logic [3:0] S_EMT_OUT = 4'd8;
  localparam logic [3:0] S_RESP    = 4'd9;

  // logical queue position to ram address
  function automatic logic [AW-1:0] wrap_addr(input logic [AW-1:0] base,
                                              input logic [CW-1:0] off);
    logic [CW:0] sum;
    begin
      sum = (CW + 1)'(base) + (CW + 1)'(off);
      if (sum >= DEPTH_X) begin
        sum = sum - DEPTH_X;
      end
      return sum[AW-1:0];
    end
  endfunction

  logic [3:0]     state_q, state_d;
  logic [IDW-1:0] id_q, id_d;
  logic [T_W-1:0] dl_q, dl_d;
  logic [T_W-1:0] now_q, now_d;
  logic [AW-1:0]  head_q, head_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [CW-1:0]  idx_q, idx_d;
  logic [CW-1:0]  wr_q, wr_d;
  logic [CW-1:0]  k_q, k_d;
  logic [T_W-1:0] fin_dl_q, fin_dl_d;
  logic           fin_empty_q, fin_empty_d;
  logic [T_W-1:0] head_dl_q, head_dl_d;
  event_e         ev_q, ev_d;

  logic            ov_q, ov_d;
  event_e          oev_q, oev_d;
  logic [ID_W-1:0] oid_q, oid_d;
  logic [T_W-1:0]  odl_q, odl_d;
  logic            oemp_q, oemp_d;
  logic            olast_q, olast_d;

  logic           ram_we, ram_re;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [DW-1:0]  ram_wdata, ram_rdata;
  logic [T_W-1:0] rd_dl;
  logic [IDW-1:0] rd_id;

  logic           in_acc;
  logic           ofree;
  logic [T_W:0]   dl_sum;
  logic [T_W-1:0] dl_in;

  // entry store, deadline above id
  sdtq_ram #(
    .WIDTH(DW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_dl = ram_rdata[DW-1:IDW];
  assign rd_id = ram_rdata[IDW-1:0];

  // handshake
  assign in_acc     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign ofree      = !ov_q || !out_stall_i;

  // deadline, relative form saturates
  assign dl_sum = {1'b0, now_i} + {1'b0, duration_i};
  assign dl_in  = !is_relative_i ? duration_i :
                  (dl_sum[T_W] ? {T_W{1'b1}} : dl_sum[T_W-1:0]);

  // sequencer
  always_comb begin
    state_d     = state_q;
    id_d        = id_q;
    dl_d        = dl_q;
    now_d       = now_q;
    head_d      = head_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    wr_d        = wr_q;
    k_d         = k_q;
    fin_dl_d    = fin_dl_q;
    fin_empty_d = fin_empty_q;
    head_dl_d   = head_dl_q;
    ev_d        = ev_q;

    ov_d    = ov_q && out_stall_i;
    oev_d   = oev_q;
    oid_d   = oid_q;
    odl_d   = odl_q;
    oemp_d  = oemp_q;
    olast_d = olast_q;

    ram_we    = 1'b0;
    ram_waddr = wrap_addr(head_q, idx_q);
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = wrap_addr(head_q, idx_q);

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          id_d  = timer_id_i[IDW-1:0];
          dl_d  = dl_in;
          now_d = now_i;
          idx_d = '0;
          wr_d  = '0;
          unique case (kind_e'(kind_i))
            KIND_START: begin
              if (cnt_q == DEPTH_C) begin
                ev_d    = EV_FULL;
                state_d = S_RESP;
              end else begin
                idx_d   = cnt_q;
                state_d = S_INS_RD;
              end
            end
            KIND_STOP: begin
              state_d = S_STP_RD;
            end
            KIND_TICK: begin
              state_d = S_SCN_RD;
            end
            KIND_CLOCK: begin
              k_d         = cnt_q;
              fin_dl_d    = '0;
              fin_empty_d = 1'b1;
              if (cnt_q == '0) begin
                id_d    = '0;
                ev_d    = EV_ACK;
                state_d = S_RESP;
              end else begin
                ev_d    = EV_CANCELLED;
                state_d = S_EMT_RD;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      // insert: walk back from the tail, moving later deadlines up by one
      S_INS_RD: begin
        if (idx_q == '0) begin
          ram_we    = 1'b1;
          ram_waddr = wrap_addr(head_q, idx_q);
          ram_wdata = {dl_q, id_q};
          head_dl_d = dl_q;
          cnt_d     = cnt_q + ONE_C;
          ev_d      = EV_ACK;
          state_d   = S_RESP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = wrap_addr(head_q, idx_q - ONE_C);
          state_d   = S_INS_CMP;
        end
      end

      S_INS_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = wrap_addr(head_q, idx_q);
        if (rd_dl > dl_q) begin
          ram_wdata = ram_rdata;
          idx_d     = idx_q - ONE_C;
          state_d   = S_INS_RD;
        end else begin
          ram_wdata = {dl_q, id_q};
          cnt_d     = cnt_q + ONE_C;
          ev_d      = EV_ACK;
          state_d   = S_RESP;
        end
      end

      // stop: compact the queue, dropping every entry of this id
      S_STP_RD: begin
        if (idx_q == cnt_q) begin
          cnt_d   = wr_q;
          ev_d    = EV_ACK;
          state_d = S_RESP;
        end else begin
          ram_re  = 1'b1;
          state_d = S_STP_CMP;
        end
      end

      S_STP_CMP: begin
        if (rd_id != id_q) begin
          ram_we    = 1'b1;
          ram_waddr = wrap_addr(head_q, wr_q);
          ram_wdata = ram_rdata;
          wr_d      = wr_q + ONE_C;
          if (wr_q == '0) begin
            head_dl_d = rd_dl;
          end
        end
        idx_d   = idx_q + ONE_C;
        state_d = S_STP_RD;
      end

      // tick: count due entries from the head, keep the first one left
      S_SCN_RD: begin
        if (idx_q == cnt_q) begin
          fin_dl_d    = '0;
          fin_empty_d = 1'b1;
          k_d         = idx_q;
          if (idx_q == '0) begin
            id_d    = '0;
            ev_d    = EV_ACK;
            state_d = S_RESP;
          end else begin
            idx_d   = '0;
            ev_d    = EV_EXPIRED;
            state_d = S_EMT_RD;
          end
        end else begin
          ram_re  = 1'b1;
          state_d = S_SCN_CMP;
        end
      end

      S_SCN_CMP: begin
        if (rd_dl <= now_q) begin
          idx_d   = idx_q + ONE_C;
          state_d = S_SCN_RD;
        end else begin
          fin_dl_d    = rd_dl;
          fin_empty_d = 1'b0;
          k_d         = idx_q;
          if (idx_q == '0) begin
            id_d    = '0;
            ev_d    = EV_ACK;
            state_d = S_RESP;
          end else begin
            idx_d   = '0;
            ev_d    = EV_EXPIRED;
            state_d = S_EMT_RD;
          end
        end
      end

      // report popped or cancelled entries in queue order
      S_EMT_RD: begin
        ram_re  = 1'b1;
        state_d = S_EMT_OUT;
      end

      S_EMT_OUT: begin
        if (ofree) begin
          ov_d    = 1'b1;
          oev_d   = ev_q;
          oid_d   = ID_W'(rd_id);
          odl_d   = fin_dl_q;
          oemp_d  = fin_empty_q;
          olast_d = (idx_q == k_q - ONE_C);
          if (idx_q == k_q - ONE_C) begin
            head_d    = wrap_addr(head_q, k_q);
            cnt_d     = cnt_q - k_q;
            head_dl_d = fin_dl_q;
            state_d   = S_IDLE;
          end else begin
            idx_d   = idx_q + ONE_C;
            state_d = S_EMT_RD;
          end
        end
      end

      // single result from the queue state as it now stands
      S_RESP: begin
        if (ofree) begin
          ov_d    = 1'b1;
          oev_d   = ev_q;
          oid_d   = ID_W'(id_q);
          odl_d   = (cnt_q != '0) ? head_dl_q : '0;
          oemp_d  = (cnt_q == '0);
          olast_d = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    id_q        <= id_d;
    dl_q        <= dl_d;
    now_q       <= now_d;
    idx_q       <= idx_d;
    wr_q        <= wr_d;
    k_q         <= k_d;
    fin_dl_q    <= fin_dl_d;
    fin_empty_q <= fin_empty_d;
    head_dl_q   <= head_dl_d;
    ev_q        <= ev_d;
    oev_q       <= oev_d;
    oid_q       <= oid_d;
    odl_q       <= odl_d;
    oemp_q      <= oemp_d;
    olast_q     <= olast_d;
  end

  assign out_valid_o     = ov_q;
  assign event_res_o     = oev_q;
  assign timer_id_res_o  = oid_q;
  assign next_deadline_o = odl_q;
  assign queue_empty_o   = oemp_q;
  assign last_o          = olast_q;

  // fill level stays within the store
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DEPTH_C)
    else $error("entry count above depth");

  // a read never meets a write to the same entry
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("ram read and write collide");

  // only insert and stop passes modify the store
  a_we_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_INS_RD || state_q == S_INS_CMP || state_q == S_STP_CMP))
    else $error("ram write outside insert or stop");

  // the report pass stays inside the popped range
  a_emit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMT_OUT) |-> (k_q != '0 && idx_q < k_q))
    else $error("report index out of range");

  // every accepted item starts work
  a_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != S_IDLE))
    else $error("accepted item left idle");

endmodule
